// ===== rtl/rsfd_pkg.sv =====
// Package for the RFID serial frame decoder: widths, codes, reset values,
// the control structs between the top level and the frame decoder, and the
// hex digit helper. Depends on nothing.
`default_nettype none

package rsfd_pkg;

    localparam int MAX_FRAME = 16;
    localparam int FRAME_AW  = $clog2(MAX_FRAME);
    localparam int CNT_W     = $clog2(MAX_FRAME + 1);

    localparam int BYTE_W    = 8;
    localparam int ID_W      = 64;
    localparam int KIND_W    = 2;
    localparam int WINDOW_W  = 20;
    localparam int ELAPSED_W = 21;
    localparam int REG_IDX_W = 2;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    // Input command codes.
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Register indexes.
    localparam logic [REG_IDX_W-1:0] REG_START_BYTE = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_END_BYTE   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_MS  = 2'd2;

    // Register reset values.
    localparam logic [BYTE_W-1:0]   START_BYTE_RST = 8'd2;
    localparam logic [BYTE_W-1:0]   END_BYTE_RST   = 8'd3;
    localparam logic [WINDOW_W-1:0] WINDOW_MS_RST  = 20'd3000;

    // Frame kinds reported with a tag.
    localparam logic [KIND_W-1:0] KIND_BINARY    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ASCII_HEX = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ASCII_RAW = 2'd2;

    localparam logic [BYTE_W-1:0] ASCII_TYPE = 8'd2;

    // Frame geometry.
    localparam logic [CNT_W-1:0] MIN_BIN_LEN     = CNT_W'(3);
    localparam logic [CNT_W-1:0] ASCII_RAW_LEN   = CNT_W'(11);
    localparam logic [CNT_W-1:0] ASCII_HEX_LEN   = CNT_W'(12);
    localparam logic [CNT_W-1:0] ASCII_ID_DIGITS = CNT_W'(10);
    localparam logic [BYTE_W-1:0] BIN_LEN_BIAS   = 8'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] start_byte;
        logic [BYTE_W-1:0] end_byte;
    } rsfd_cfg_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } rsfd_byte_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [ID_W-1:0]   tag_id;
        logic [BYTE_W-1:0] tag_type;
        logic [KIND_W-1:0] frame_kind;
    } rsfd_dec_stat_t;

    // Digit value of an ASCII hex character; other characters wrap mod 256.
    function automatic logic [3:0] hex_nibble(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] v;
        v = c - 8'd48;
        if (v > 8'd9)
        begin
            v = v - 8'd7;
        end
        return v[3:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rsfd_channels.sv =====
// Valid/ready stream interfaces for the input and result channels of the
// RFID serial frame decoder. No dependencies.
`default_nettype none

interface rsfd_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface rsfd_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] tag_id;
    logic [7:0]  tag_type;
    logic [1:0]  frame_kind;

    modport source (output valid, output tag_id, output tag_type, output frame_kind,
                    input ready);
    modport sink   (input valid, input tag_id, input tag_type, input frame_kind,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/rfid_serial_frame_decoder_unit.sv =====
// Top level of the RFID serial frame decoder: APB register file, millisecond
// counter, repeat filter and result register. Uses rsfd_pkg, rsfd_channels,
// rsfd_frame_dec.
//
//   Channel   Direction  Handshake            Payload
//   in_ch     sink       valid/ready          command, data_byte
//   out_ch    source     valid/ready          tag_id, tag_type, frame_kind
//   APB       slave      psel/penable/pready  paddr[3:0], pwdata, prdata
//
// An end byte that closes a frame of at least three bytes starts a walk over
// the frame store, one byte per cycle through its single read port, then a
// check state and a done state that holds the tag until it is taken. The
// input is not ready during the walk.
// A decoded tag waits in the decoder while the result register still holds an
// earlier tag; a new request is taken while a finished result waits.
// Reset (rst_n, asynchronous, active low) restores the register defaults and
// clears the frame count, the last reported ID and the millisecond counter.
`default_nettype none

module rfid_serial_frame_decoder_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rsfd_pkg::PADDR_W-1:0]  paddr,
    input  logic [rsfd_pkg::PDATA_W-1:0]  pwdata,
    output logic [rsfd_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    rsfd_in_if.sink                       in_ch,
    rsfd_out_if.source                    out_ch
);
    import rsfd_pkg::*;

    // Configuration registers.
    logic [BYTE_W-1:0]    start_reg;
    logic [BYTE_W-1:0]    end_reg;
    logic [WINDOW_W-1:0]  window_reg;

    // Repeat filter state.
    logic [ID_W-1:0]      prev_id_reg;
    logic [ELAPSED_W-1:0] elapsed_reg;

    // Result register.
    logic                 out_valid_reg;
    logic [ID_W-1:0]      tag_id_reg;
    logic [BYTE_W-1:0]    tag_type_reg;
    logic [KIND_W-1:0]    frame_kind_reg;

    logic [REG_IDX_W-1:0] reg_idx;
    logic                 apb_wr;
    logic                 in_take;
    logic                 tick;
    logic                 out_free;
    logic                 emit;
    logic                 out_load;
    logic                 dec_ack;

    rsfd_cfg_t      dec_cfg;
    rsfd_byte_req_t dec_req;
    rsfd_dec_stat_t dec_stat;

    // APB: pready is tied high, so every access completes in its access cycle.
    assign reg_idx = paddr[PADDR_W-1:2];
    assign apb_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb
    begin
        unique case (reg_idx)
            REG_START_BYTE: prdata = PDATA_W'(start_reg);
            REG_END_BYTE:   prdata = PDATA_W'(end_reg);
            REG_WINDOW_MS:  prdata = PDATA_W'(window_reg);
            default:        prdata = '0;
        endcase
    end

    // Input side: requests are refused only while the decoder walks or checks a
    // frame or holds a tag for the result register.
    assign in_ch.ready  = !dec_stat.busy;
    assign in_take      = in_ch.valid && in_ch.ready;
    assign tick         = in_take && (in_ch.command == CMD_TICK);
    assign dec_req.valid = in_take && (in_ch.command == CMD_BYTE);
    assign dec_req.data  = in_ch.data_byte;
    assign dec_cfg.start_byte = start_reg;
    assign dec_cfg.end_byte   = end_reg;

    // A good tag is reported when it differs from the last one, or when the
    // repeat window has run out since the last report.
    assign emit     = (elapsed_reg > ELAPSED_W'(window_reg)) || (dec_stat.tag_id != prev_id_reg);
    assign out_free = !out_valid_reg || out_ch.ready;
    assign out_load = dec_stat.done && emit && out_free;
    assign dec_ack  = dec_stat.done && (!emit || out_free);

    rsfd_frame_dec u_frame_dec (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (dec_cfg),
        .req   (dec_req),
        .ack   (dec_ack),
        .stat  (dec_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg     <= START_BYTE_RST;
            end_reg       <= END_BYTE_RST;
            window_reg    <= WINDOW_MS_RST;
            prev_id_reg   <= '0;
            elapsed_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (apb_wr)
            begin
                unique case (reg_idx)
                    REG_START_BYTE: start_reg  <= pwdata[BYTE_W-1:0];
                    REG_END_BYTE:   end_reg    <= pwdata[BYTE_W-1:0];
                    REG_WINDOW_MS:  window_reg <= pwdata[WINDOW_W-1:0];
                    default:        ;
                endcase
            end

            // Ticks and reports never meet: ticks are refused during a decode.
            if (out_load)
            begin
                prev_id_reg <= dec_stat.tag_id;
                elapsed_reg <= '0;
            end
            else if (tick && (elapsed_reg != '1))
            begin
                elapsed_reg <= elapsed_reg + ELAPSED_W'(1);
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            tag_id_reg     <= dec_stat.tag_id;
            tag_type_reg   <= dec_stat.tag_type;
            frame_kind_reg <= dec_stat.frame_kind;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.tag_id     = tag_id_reg;
    assign out_ch.tag_type   = tag_type_reg;
    assign out_ch.frame_kind = frame_kind_reg;

    a_report_updates: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (prev_id_reg == tag_id_reg) && (elapsed_reg == '0) && out_valid_reg)
        else $error("report did not update the repeat filter");

    a_tag_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (dec_stat.done && emit && out_valid_reg && !out_ch.ready) |=> dec_stat.done)
        else $error("tag released while the result register was full");

    a_no_tick_in_decode: assert property (@(posedge clk) disable iff (!rst_n)
        dec_stat.busy |-> !tick)
        else $error("tick counted during a decode");

endmodule

`default_nettype wire

// ===== rtl/rsfd_frame_dec.sv =====
// Frame buffer and decode sequencer: stores frame bytes in a small memory and
// walks them through an ID shift register and an XOR checksum. Uses rsfd_pkg.
`default_nettype none

module rsfd_frame_dec (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rsfd_pkg::rsfd_cfg_t      cfg,
    input  rsfd_pkg::rsfd_byte_req_t req,
    input  logic                   ack,
    output rsfd_pkg::rsfd_dec_stat_t stat
);
    import rsfd_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_CHECK, ST_DONE} dec_state_t;

    dec_state_t        state_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              ovf_reg;
    logic [CNT_W-1:0]  len_reg;
    logic [CNT_W-1:0]  issue_reg;
    logic [CNT_W-1:0]  proc_reg;
    logic              rd_vld_reg;
    logic [BYTE_W-1:0] rd_data_reg;
    logic              bin_reg;
    logic [BYTE_W-1:0] sum_reg;
    logic [BYTE_W-1:0] got_reg;
    logic [BYTE_W-1:0] type_reg;
    logic [ID_W-1:0]   id_reg;

    logic [BYTE_W-1:0] frame_mem [MAX_FRAME];

    logic              is_start;
    logic              is_end;
    logic              wr_en;
    logic [3:0]        nib;
    logic              last_byte;
    logic              bin_first;
    logic              ascii_len;
    logic              len_hex;
    logic [BYTE_W-1:0] ascii_sum;

    assign is_start  = (req.data == cfg.start_byte) && (cnt_reg != CNT_W'(1));
    assign is_end    = (req.data == cfg.end_byte);
    assign wr_en     = req.valid && (state_reg == ST_IDLE) && !is_start && !is_end
                       && (cnt_reg < CNT_W'(MAX_FRAME));
    assign nib       = hex_nibble(rd_data_reg);
    assign last_byte = (proc_reg == (len_reg - CNT_W'(1)));
    assign bin_first = (rd_data_reg == (BYTE_W'(len_reg) + BIN_LEN_BIAS));
    assign len_hex   = (len_reg == ASCII_HEX_LEN);
    assign ascii_len = len_hex || (len_reg == ASCII_RAW_LEN);
    assign ascii_sum = id_reg[39:32] ^ id_reg[31:24] ^ id_reg[23:16]
                     ^ id_reg[15:8] ^ id_reg[7:0];

    // Frame store: one write port while buffering, one registered read port
    // for the walk.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            frame_mem[cnt_reg[FRAME_AW-1:0]] <= req.data;
        end
        rd_data_reg <= frame_mem[issue_reg[FRAME_AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            ovf_reg    <= 1'b0;
            len_reg    <= '0;
            issue_reg  <= '0;
            proc_reg   <= '0;
            rd_vld_reg <= 1'b0;
            bin_reg    <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req.valid)
                    begin
                        priority if (is_start)
                        begin
                            cnt_reg <= '0;
                            ovf_reg <= 1'b0;
                        end
                        else if (!is_end)
                        begin
                            if (cnt_reg < CNT_W'(MAX_FRAME))
                            begin
                                cnt_reg <= cnt_reg + CNT_W'(1);
                            end
                            else
                            begin
                                ovf_reg <= 1'b1;
                            end
                        end
                        else
                        begin
                            cnt_reg <= '0;
                            ovf_reg <= 1'b0;
                            if (!ovf_reg && (cnt_reg >= MIN_BIN_LEN))
                            begin
                                len_reg    <= cnt_reg;
                                issue_reg  <= '0;
                                proc_reg   <= '0;
                                rd_vld_reg <= 1'b0;
                                state_reg  <= ST_WALK;
                            end
                        end
                    end
                end
                ST_WALK:
                begin
                    issue_reg  <= issue_reg + CNT_W'(1);
                    rd_vld_reg <= 1'b1;
                    if (rd_vld_reg)
                    begin
                        proc_reg <= proc_reg + CNT_W'(1);
                        priority if (proc_reg == '0)
                        begin
                            // The first byte decides between binary and ASCII.
                            bin_reg <= bin_first;
                            sum_reg <= rd_data_reg;
                            id_reg  <= bin_first ? '0 : ID_W'(nib);
                            if (!bin_first && !ascii_len)
                            begin
                                state_reg <= ST_IDLE;
                            end
                        end
                        else if (bin_reg)
                        begin
                            if (last_byte)
                            begin
                                got_reg   <= rd_data_reg;
                                state_reg <= ST_CHECK;
                            end
                            else
                            begin
                                sum_reg <= sum_reg ^ rd_data_reg;
                                if (proc_reg == CNT_W'(1))
                                begin
                                    type_reg <= rd_data_reg;
                                end
                                else
                                begin
                                    id_reg <= {id_reg[ID_W-BYTE_W-1:0], rd_data_reg};
                                end
                            end
                        end
                        else if (proc_reg < ASCII_ID_DIGITS)
                        begin
                            id_reg <= {id_reg[ID_W-5:0], nib};
                        end
                        else if (!len_hex)
                        begin
                            got_reg   <= rd_data_reg;
                            state_reg <= ST_CHECK;
                        end
                        else
                        begin
                            got_reg <= {got_reg[3:0], nib};
                            if (last_byte)
                            begin
                                state_reg <= ST_CHECK;
                            end
                        end
                    end
                end
                ST_CHECK:
                begin
                    if ((bin_reg ? sum_reg : ascii_sum) == got_reg)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_DONE:
                begin
                    if (ack)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        stat.busy       = (state_reg != ST_IDLE);
        stat.done       = (state_reg == ST_DONE);
        stat.tag_id     = id_reg;
        stat.tag_type   = bin_reg ? type_reg : ASCII_TYPE;
        stat.frame_kind = bin_reg ? KIND_BINARY : (len_hex ? KIND_ASCII_HEX : KIND_ASCII_RAW);
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_FRAME))
        else $error("frame byte count above buffer depth");

    a_req_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid |-> (state_reg == ST_IDLE))
        else $error("byte request while a decode is running");

    a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK && rd_vld_reg) |-> (proc_reg < len_reg))
        else $error("walk ran past the frame length");

    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !ack) |=> (state_reg == ST_DONE))
        else $error("decoded tag dropped before acknowledge");

endmodule

`default_nettype wire
